### hdl/lrj_pkg.sv
// shared types and constants for the loop roll and jump controller
package lrj_pkg;

  localparam int unsigned ROLL_STEP = 4;
  localparam logic [7:0]  ROLL_MAX  = 8'((255 / ROLL_STEP) * ROLL_STEP);
  localparam logic [7:0]  NO_CUE    = 8'd255;
  localparam logic [7:0]  LEN_RESET = 8'd4;

  typedef enum logic [2:0] {
    OP_FRAME = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_CUE   = 3'd3,
    OP_LOCK  = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ADV1,
    ST_ARM,
    ST_ADV2,
    ST_MOD,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic load_in;
    logic start_adv;
    logic start_mod;
    logic step;
    logic commit_adv1;
    logic arm_set;
    logic commit_adv2;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_frame;
    logic need_adv1;
    logic need_mod;
    logic arm_fire;
    logic arm_stop;
    logic unit_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/lrj_ctrl.sv
// controller state machine sequencing one request through the datapath
module lrj_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lrj_pkg::dp_sts_t sts,
  output lrj_pkg::dp_cmd_t cmd
);

  lrj_pkg::st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrj_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lrj_pkg::ST_IDLE: begin
        if (in_valid) state_next = lrj_pkg::ST_EVAL;
      end
      lrj_pkg::ST_EVAL: begin
        if (sts.is_frame) begin
          state_next = sts.need_adv1 ? lrj_pkg::ST_ADV1 : lrj_pkg::ST_ARM;
        end else if (sts.need_mod) begin
          state_next = lrj_pkg::ST_MOD;
        end else begin
          state_next = lrj_pkg::ST_FIN;
        end
      end
      lrj_pkg::ST_ADV1: begin
        if (sts.unit_done) state_next = lrj_pkg::ST_ARM;
      end
      lrj_pkg::ST_ARM: begin
        state_next = (sts.arm_fire && sts.arm_stop) ? lrj_pkg::ST_ADV2 : lrj_pkg::ST_FIN;
      end
      lrj_pkg::ST_ADV2: begin
        if (sts.unit_done) state_next = lrj_pkg::ST_FIN;
      end
      lrj_pkg::ST_MOD: begin
        if (sts.unit_done) state_next = lrj_pkg::ST_FIN;
      end
      lrj_pkg::ST_FIN: begin
        if (sts.out_free) state_next = lrj_pkg::ST_IDLE;
      end
      default: state_next = lrj_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      lrj_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      lrj_pkg::ST_EVAL: begin
        cmd.start_adv = sts.is_frame && sts.need_adv1;
        cmd.start_mod = !sts.is_frame && sts.need_mod;
      end
      lrj_pkg::ST_ADV1: begin
        cmd.step        = !sts.unit_done;
        cmd.commit_adv1 = sts.unit_done;
      end
      lrj_pkg::ST_ARM: begin
        cmd.start_adv = sts.arm_fire && sts.arm_stop;
        cmd.arm_set   = sts.arm_fire && !sts.arm_stop;
      end
      lrj_pkg::ST_ADV2: begin
        cmd.step        = !sts.unit_done;
        cmd.commit_adv2 = sts.unit_done;
      end
      lrj_pkg::ST_MOD: begin
        cmd.step = !sts.unit_done;
      end
      lrj_pkg::ST_FIN: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### hdl/lrj_dp.sv
// datapath: request latch, roll and shadow state, wrap and remainder unit, result register
module lrj_dp (
  input  logic             clk,
  input  logic             rst,
  input  lrj_pkg::dp_cmd_t cmd,
  output lrj_pkg::dp_sts_t sts,
  input  logic [2:0]       command,
  input  logic [7:0]       play_pos,
  input  logic [7:0]       play_row,
  input  logic [7:0]       pattern_last_row,
  input  logic [7:0]       song_orders,
  input  logic             is_playing,
  input  logic             jump_idle,
  input  logic [7:0]       roll_rows,
  input  logic [7:0]       cue_pos,
  input  logic             lock_on,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             jump_set,
  output logic [7:0]       jump_pos,
  output logic [7:0]       jump_row,
  output logic             jump_cancel,
  output logic             roll_on
);

  // latched request
  logic [2:0] cmd_q;
  logic [7:0] pos_q, row_q, plr_q, ord_q, rrows_q, cue_q;
  logic       play_q, idle_q, lock_q;

  // block state
  logic       roll_active, roll_stopping, jump_armed, lock_enabled;
  logic [7:0] roll_start_pos, roll_start_row, roll_length;
  logic [7:0] shadow_pos, shadow_row, hotcue_target;

  // pending roll result
  logic       res_set, fired;
  logic [7:0] res_pos, res_row;

  // repeated subtraction unit
  logic [8:0] acc, dvs;
  logic [7:0] upos;
  logic       upos_en;

  logic [8:0] per_patt, olen, adv_sum, last_raw, last_c, p1, sum9, rnd9;
  logic [7:0] upos_inc, qlen, anchor_row;
  logic       unit_done, arm, out_free, cue_fire, lock_fire;
  logic       fin_set, fin_cancel, fin_active;
  logic [7:0] fin_pos, fin_row;

  assign per_patt  = {1'b0, plr_q} + 9'd1;
  assign olen      = (ord_q == 8'd0) ? 9'd1 : {1'b0, ord_q};
  assign adv_sum   = {1'b0, shadow_row} + {1'b0, roll_length};
  assign p1        = {1'b0, upos} + 9'd1;
  assign upos_inc  = (p1 >= olen) ? 8'd0 : p1[7:0];
  assign unit_done = acc < dvs;

  assign sum9 = {1'b0, rrows_q} + 9'(lrj_pkg::ROLL_STEP - 1);
  assign rnd9 = (sum9 / 9'(lrj_pkg::ROLL_STEP)) * 9'(lrj_pkg::ROLL_STEP);
  assign qlen = (rrows_q < 8'(lrj_pkg::ROLL_STEP)) ? 8'(lrj_pkg::ROLL_STEP) :
                (rnd9 > 9'd255) ? lrj_pkg::ROLL_MAX : rnd9[7:0];
  assign anchor_row = row_q - acc[7:0];

  // roll window end, clamped to the pattern
  assign last_raw = {1'b0, roll_start_row} + {1'b0, roll_length} - 9'd1;
  assign last_c   = (last_raw > {1'b0, plr_q}) ? {1'b0, plr_q} : last_raw;
  assign arm      = (pos_q != roll_start_pos) || ({1'b0, row_q} >= last_c);

  assign out_free  = !out_valid || !out_stall;
  assign cue_fire  = (hotcue_target != lrj_pkg::NO_CUE) && play_q && (row_q >= plr_q);
  assign lock_fire = lock_enabled && !roll_active && (hotcue_target == lrj_pkg::NO_CUE) &&
                     play_q && !fired && !cue_fire && (row_q >= plr_q);

  always_comb begin
    sts           = '0;
    sts.is_frame  = cmd_q == lrj_pkg::OP_FRAME;
    sts.need_adv1 = roll_active && play_q && jump_armed && idle_q;
    sts.need_mod  = (cmd_q == lrj_pkg::OP_START) && play_q && !roll_active;
    sts.arm_fire  = roll_active && play_q && arm && !jump_armed;
    sts.arm_stop  = roll_stopping;
    sts.unit_done = unit_done;
    sts.out_free  = out_free;
  end

  always_comb begin
    fin_set    = 1'b0;
    fin_pos    = 8'd0;
    fin_row    = 8'd0;
    fin_cancel = 1'b0;
    fin_active = roll_active;
    unique case (cmd_q)
      lrj_pkg::OP_FRAME: begin
        fin_set = res_set || cue_fire || lock_fire;
        fin_pos = cue_fire ? hotcue_target : (lock_fire ? pos_q : res_pos);
        fin_row = (cue_fire || lock_fire) ? 8'd0 : res_row;
      end
      lrj_pkg::OP_START: begin
        fin_cancel = play_q;
        fin_active = roll_active || play_q;
      end
      lrj_pkg::OP_CUE: begin
        fin_cancel = 1'b1;
        fin_active = 1'b0;
      end
      lrj_pkg::OP_CLEAR: begin
        fin_active = 1'b0;
      end
      default: begin
        fin_active = roll_active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q   <= command;
      pos_q   <= play_pos;
      row_q   <= play_row;
      plr_q   <= pattern_last_row;
      ord_q   <= song_orders;
      play_q  <= is_playing;
      idle_q  <= jump_idle;
      rrows_q <= roll_rows;
      cue_q   <= cue_pos;
      lock_q  <= lock_on;
      res_set <= 1'b0;
      res_pos <= 8'd0;
      res_row <= 8'd0;
      fired   <= 1'b0;
    end else if (cmd.arm_set) begin
      res_set <= 1'b1;
      res_pos <= roll_start_pos;
      res_row <= roll_start_row;
      fired   <= 1'b1;
    end else if (cmd.commit_adv2) begin
      res_set <= 1'b1;
      res_pos <= upos;
      res_row <= acc[7:0];
      fired   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_adv) begin
      acc     <= adv_sum;
      dvs     <= per_patt;
      upos    <= shadow_pos;
      upos_en <= !lock_enabled;
    end else if (cmd.start_mod) begin
      acc     <= {1'b0, row_q};
      dvs     <= {1'b0, qlen};
      upos    <= shadow_pos;
      upos_en <= 1'b0;
    end else if (cmd.step && !unit_done) begin
      acc <= acc - dvs;
      if (upos_en) upos <= upos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_active    <= 1'b0;
      roll_stopping  <= 1'b0;
      roll_start_pos <= 8'd0;
      roll_start_row <= 8'd0;
      roll_length    <= lrj_pkg::LEN_RESET;
      jump_armed     <= 1'b0;
      shadow_pos     <= 8'd0;
      shadow_row     <= 8'd0;
      hotcue_target  <= lrj_pkg::NO_CUE;
      lock_enabled   <= 1'b0;
    end else begin
      if (cmd.commit_adv1) begin
        shadow_row <= acc[7:0];
        shadow_pos <= upos;
        jump_armed <= 1'b0;
      end
      if (cmd.arm_set) jump_armed <= 1'b1;
      if (cmd.commit_adv2) begin
        shadow_row    <= acc[7:0];
        shadow_pos    <= upos;
        roll_active   <= 1'b0;
        roll_stopping <= 1'b0;
        jump_armed    <= 1'b1;
      end
      if (cmd.finish) begin
        unique case (cmd_q)
          lrj_pkg::OP_FRAME: begin
            if (cue_fire) hotcue_target <= lrj_pkg::NO_CUE;
          end
          lrj_pkg::OP_START: begin
            if (play_q) begin
              roll_stopping <= 1'b0;
              roll_length   <= qlen;
              jump_armed    <= 1'b0;
              if (!roll_active) begin
                roll_start_pos <= pos_q;
                roll_start_row <= anchor_row;
                roll_active    <= 1'b1;
                shadow_pos     <= pos_q;
                shadow_row     <= anchor_row;
              end
            end
          end
          lrj_pkg::OP_STOP: begin
            if (roll_active) roll_stopping <= 1'b1;
          end
          lrj_pkg::OP_CUE: begin
            roll_active   <= 1'b0;
            roll_stopping <= 1'b0;
            jump_armed    <= 1'b0;
            hotcue_target <= cue_q;
          end
          lrj_pkg::OP_LOCK: begin
            lock_enabled <= lock_q;
          end
          lrj_pkg::OP_CLEAR: begin
            roll_active    <= 1'b0;
            roll_stopping  <= 1'b0;
            roll_start_pos <= 8'd0;
            roll_start_row <= 8'd0;
            roll_length    <= lrj_pkg::LEN_RESET;
            jump_armed     <= 1'b0;
            shadow_pos     <= 8'd0;
            shadow_row     <= 8'd0;
            hotcue_target  <= lrj_pkg::NO_CUE;
            lock_enabled   <= 1'b0;
          end
          default: begin
            lock_enabled <= lock_enabled;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      jump_set    <= fin_set;
      jump_pos    <= fin_pos;
      jump_row    <= fin_row;
      jump_cancel <= fin_cancel;
      roll_on     <= fin_active;
    end
  end

endmodule

### hdl/loop_roll_jump_controller.sv
// top level: loop roll and jump controller, controller plus datapath
// one request in flight; result registered through the evaluate and finish states, a frame also passing arm
// a frame shadow advance steps the subtraction unit over each wrap; a stop jump may add a second
// start roll from rest reduces the row modulo the roll length in the same unit
// next request accepted in the cycle after the result is registered, even if it is still stalled
// synchronous reset clears roll state, no hotcue pending, roll length 4, output empty
module loop_roll_jump_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] play_pos,
  input  logic [7:0] play_row,
  input  logic [7:0] pattern_last_row,
  input  logic [7:0] song_orders,
  input  logic       is_playing,
  input  logic       jump_idle,
  input  logic [7:0] roll_rows,
  input  logic [7:0] cue_pos,
  input  logic       lock_on,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       jump_set,
  output logic [7:0] jump_pos,
  output logic [7:0] jump_row,
  output logic       jump_cancel,
  output logic       roll_on
);

  lrj_pkg::dp_cmd_t cmd;
  lrj_pkg::dp_sts_t sts;

  lrj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrj_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .command          (command),
    .play_pos         (play_pos),
    .play_row         (play_row),
    .pattern_last_row (pattern_last_row),
    .song_orders      (song_orders),
    .is_playing       (is_playing),
    .jump_idle        (jump_idle),
    .roll_rows        (roll_rows),
    .cue_pos          (cue_pos),
    .lock_on          (lock_on),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .jump_set         (jump_set),
    .jump_pos         (jump_pos),
    .jump_row         (jump_row),
    .jump_cancel      (jump_cancel),
    .roll_on          (roll_on)
  );

endmodule

### hdl/lrj_checker.sv
// port-level checks for the loop roll and jump controller, bound to the top level
module lrj_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       jump_set,
  input logic [7:0] jump_pos,
  input logic [7:0] jump_row,
  input logic       jump_cancel,
  input logic       roll_on
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_busy_after_accept: assert property (@(posedge clk)
    (!rst && in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in work");

  a_no_jump_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !jump_set) |-> (jump_pos == 8'd0 && jump_row == 8'd0))
    else $error("jump target without jump");

  a_cancel_excl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && jump_cancel) |-> !jump_set)
    else $error("cancel and jump in one result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(jump_set) && $stable(jump_pos) && $stable(jump_row) &&
       $stable(jump_cancel) && $stable(roll_on)))
    else $error("stalled result changed");

endmodule

bind loop_roll_jump_controller lrj_checker u_lrj_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the loop roll and jump controller: directed table then random sessions
module testbench;

  localparam int N_ITEMS      = 1500;
  localparam int CALM_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 1100;
  localparam int CYCLE_LIMIT  = N_ITEMS * 1100 * 4;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pos;
    logic [7:0] row;
    logic [7:0] plr;
    logic [7:0] orders;
    logic       playing;
    logic       idle;
    logic [7:0] rrows;
    logic [7:0] cue;
    logic       lock;
  } jump_req_t;

  typedef struct packed {
    logic       set;
    logic [7:0] pos;
    logic [7:0] row;
    logic       cancel;
    logic       roll;
  } jump_res_t;

  typedef struct packed {
    jump_req_t req;
    logic      typed;
    jump_res_t res;
  } plan_row_t;

  localparam jump_res_t NO_JUMP = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [2:0] command = '0;
  logic [7:0] play_pos = '0;
  logic [7:0] play_row = '0;
  logic [7:0] pattern_last_row = '0;
  logic [7:0] song_orders = '0;
  logic       is_playing = 1'b0;
  logic       jump_idle = 1'b0;
  logic [7:0] roll_rows = '0;
  logic [7:0] cue_pos = '0;
  logic       lock_on = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       jump_set;
  logic [7:0] jump_pos;
  logic [7:0] jump_row;
  logic       jump_cancel;
  logic       roll_on;

  loop_roll_jump_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .play_pos(play_pos), .play_row(play_row),
    .pattern_last_row(pattern_last_row), .song_orders(song_orders),
    .is_playing(is_playing), .jump_idle(jump_idle), .roll_rows(roll_rows),
    .cue_pos(cue_pos), .lock_on(lock_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .jump_set(jump_set), .jump_pos(jump_pos), .jump_row(jump_row),
    .jump_cancel(jump_cancel), .roll_on(roll_on)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // fields: cmd, pos, row, last row, orders, playing, idle, roll rows, cue, lock
  plan_row_t plan [26] = '{
    '{'{lrj_pkg::OP_FRAME, 8'd0, 8'd255, 8'd255, 8'd1, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
      1'b1, NO_JUMP},
    '{'{OP_SPARE7, 8'd254, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 1'b1},
      1'b1, NO_JUMP},
    '{'{OP_SPARE6, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}, 1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_START, 8'd5, 8'd9, 8'd63, 8'd8, 1'b0, 1'b1, 8'd8, 8'd0, 1'b0},
      1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_LOCK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1},
      1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_FRAME, 8'd17, 8'd63, 8'd63, 8'd32, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd17, 8'd0, 1'b0, 1'b0}},
    '{'{lrj_pkg::OP_FRAME, 8'd17, 8'd255, 8'd0, 8'd32, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0},
      1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_LOCK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0},
      1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_START, 8'd3, 8'd13, 8'd63, 8'd8, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{lrj_pkg::OP_FRAME, 8'd3, 8'd15, 8'd63, 8'd8, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd3, 8'd12, 1'b0, 1'b1}},
    '{'{lrj_pkg::OP_FRAME, 8'd3, 8'd12, 8'd63, 8'd8, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_START, 8'd3, 8'd14, 8'd63, 8'd8, 1'b1, 1'b0, 8'd255, 8'd0, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{lrj_pkg::OP_START, 8'd3, 8'd14, 8'd63, 8'd8, 1'b1, 1'b0, 8'd5, 8'd0, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_STOP, 8'd3, 8'd14, 8'd63, 8'd8, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{lrj_pkg::OP_FRAME, 8'd4, 8'd0, 8'd255, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_STOP, 8'd4, 8'd0, 8'd255, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0},
      1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_CUE, 8'd4, 8'd0, 8'd255, 8'd0, 1'b1, 1'b0, 8'd0, 8'd254, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0}},
    '{'{lrj_pkg::OP_FRAME, 8'd4, 8'd255, 8'd0, 8'd9, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd254, 8'd0, 1'b0, 1'b0}},
    '{'{lrj_pkg::OP_START, 8'd0, 8'd255, 8'd255, 8'd9, 1'b1, 1'b1, 8'd64, 8'd0, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_CUE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd255, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0}},
    '{'{lrj_pkg::OP_CUE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd100, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_LOCK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_FRAME, 8'd9, 8'd50, 8'd50, 8'd16, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_START, 8'd254, 8'd0, 8'd50, 8'd16, 1'b1, 1'b1, 8'd1, 8'd0, 1'b0},
      1'b0, NO_JUMP},
    '{'{lrj_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
      1'b1, NO_JUMP},
    '{'{lrj_pkg::OP_FRAME, 8'd254, 8'd255, 8'd255, 8'd16, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
      1'b1, NO_JUMP}
  };

  logic       r_active;
  logic       r_stopping;
  logic [7:0] r_pos;
  logic [7:0] r_row;
  logic [7:0] r_len;
  logic       armed;
  logic [7:0] sh_pos;
  logic [7:0] sh_row;
  logic [7:0] cue_tgt;
  logic       locked;

  jump_res_t pending_jumps [$];
  jump_res_t last_jump;
  jump_res_t got_res;
  jump_res_t want_res;
  int n_items = 0;
  int n_bad = 0;
  int n_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int pl_pos, pl_row, pl_last, pl_orders;

  function automatic void clear_roll_state();
    r_active = 1'b0;
    r_stopping = 1'b0;
    r_pos = '0;
    r_row = '0;
    r_len = lrj_pkg::LEN_RESET;
    armed = 1'b0;
    sh_pos = '0;
    sh_row = '0;
    cue_tgt = lrj_pkg::NO_CUE;
    locked = 1'b0;
  endfunction

  function automatic void advance_shadow(int unsigned patt_end, int unsigned orders);
    int unsigned per, olen, r, p;
    per = patt_end + 1;
    olen = (orders == 0) ? 1 : orders;
    r = sh_row + r_len;
    p = sh_pos;
    while (r >= per) begin
      r -= per;
      if (!locked) begin
        p++;
        if (p >= olen) p = 0;
      end
    end
    sh_row = 8'(r);
    sh_pos = 8'(p);
  endfunction

  function automatic jump_res_t predict_jump(jump_req_t q);
    jump_res_t res;
    int last;
    int unsigned n;
    logic roll_fired, cue_fired, arm;
    res = '0;
    roll_fired = 1'b0;
    cue_fired = 1'b0;
    case (q.cmd)
      lrj_pkg::OP_FRAME: begin
        if (r_active && q.playing) begin
          last = int'(r_row) + int'(r_len) - 1;
          if (last > int'(q.plr)) last = int'(q.plr);
          if (armed && q.idle) begin
            advance_shadow(q.plr, q.orders);
            armed = 1'b0;
          end
          arm = (q.pos != r_pos) || (int'(q.row) >= last);
          if (arm && !armed) begin
            if (r_stopping) begin
              advance_shadow(q.plr, q.orders);
              r_active = 1'b0;
              r_stopping = 1'b0;
              res.pos = sh_pos;
              res.row = sh_row;
            end else begin
              res.pos = r_pos;
              res.row = r_row;
            end
            res.set = 1'b1;
            armed = 1'b1;
            roll_fired = 1'b1;
          end
        end
        if (cue_tgt != lrj_pkg::NO_CUE && q.playing && q.row >= q.plr) begin
          res.set = 1'b1;
          res.pos = cue_tgt;
          res.row = '0;
          cue_tgt = lrj_pkg::NO_CUE;
          cue_fired = 1'b1;
        end
        if (locked && !r_active && cue_tgt == lrj_pkg::NO_CUE && q.playing && !roll_fired &&
            !cue_fired && q.row >= q.plr) begin
          res.set = 1'b1;
          res.pos = q.pos;
          res.row = '0;
        end
      end
      lrj_pkg::OP_START: begin
        if (q.playing) begin
          // round up to the roll step, saturating below 256
          n = (q.rrows < lrj_pkg::ROLL_STEP) ? lrj_pkg::ROLL_STEP :
              ((q.rrows + lrj_pkg::ROLL_STEP - 1) / lrj_pkg::ROLL_STEP) * lrj_pkg::ROLL_STEP;
          if (n > 255) n = lrj_pkg::ROLL_MAX;
          if (!r_active) begin
            r_pos = q.pos;
            r_row = 8'(q.row - q.row % n);
            r_active = 1'b1;
            sh_pos = q.pos;
            sh_row = r_row;
          end
          r_len = 8'(n);
          r_stopping = 1'b0;
          armed = 1'b0;
          res.cancel = 1'b1;
        end
      end
      lrj_pkg::OP_STOP: begin
        if (r_active) r_stopping = 1'b1;
      end
      lrj_pkg::OP_CUE: begin
        r_active = 1'b0;
        r_stopping = 1'b0;
        armed = 1'b0;
        cue_tgt = q.cue;
        res.cancel = 1'b1;
      end
      lrj_pkg::OP_LOCK: locked = q.lock;
      lrj_pkg::OP_CLEAR: clear_roll_state();
      default: ;
    endcase
    res.roll = r_active;
    return res;
  endfunction

  task automatic send_req(input jump_req_t q, input logic typed, input jump_res_t typed_res);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= q.cmd;
    play_pos <= q.pos;
    play_row <= q.row;
    pattern_last_row <= q.plr;
    song_orders <= q.orders;
    is_playing <= q.playing;
    jump_idle <= q.idle;
    roll_rows <= q.rrows;
    cue_pos <= q.cue;
    lock_on <= q.lock;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_jump = predict_jump(q);
    pending_jumps.push_back(typed ? typed_res : last_jump);
    if (q.cmd <= lrj_pkg::OP_CLEAR) begin
      n_items++;
      // new idling mix every hundred requests, none near the end
      if (n_items >= N_ITEMS - CALM_ITEMS) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (n_items % 100 == 0) begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
    end
  endtask

  function automatic jump_req_t random_req();
    jump_req_t q;
    q.cmd = 3'($urandom_range(0, 7));
    q.pos = 8'($urandom_range(0, 254));
    q.row = 8'($urandom_range(0, 255));
    q.plr = 8'($urandom_range(0, 255));
    q.orders = 8'($urandom_range(0, 255));
    q.playing = 1'($urandom_range(0, 1));
    q.idle = 1'($urandom_range(0, 1));
    q.rrows = 8'($urandom_range(0, 255));
    q.cue = ($urandom_range(0, 7) == 0) ? lrj_pkg::NO_CUE : 8'($urandom_range(0, 254));
    q.lock = 1'($urandom_range(0, 1));
    return q;
  endfunction

  task automatic new_song();
    pl_last = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(15, 255);
    pl_orders = $urandom_range(0, 255);
    pl_pos = (pl_orders < 2) ? 0 : $urandom_range(0, (pl_orders > 255) ? 254 : pl_orders - 1);
    if (pl_pos > 254) pl_pos = 254;
    pl_row = $urandom_range(0, pl_last);
  endtask

  task automatic send_frame(input logic playing);
    jump_req_t q;
    q = random_req();
    q.cmd = lrj_pkg::OP_FRAME;
    q.pos = 8'(pl_pos);
    q.row = 8'(pl_row);
    q.plr = 8'(pl_last);
    q.orders = 8'(pl_orders);
    q.playing = playing;
    send_req(q, 1'b0, NO_JUMP);
    // player mostly follows a jump request, otherwise moves on a few rows
    if (last_jump.set && $urandom_range(0, 2) != 0) begin
      pl_pos = last_jump.pos;
      pl_row = last_jump.row;
    end else if (playing) begin
      pl_row += $urandom_range(0, 3);
      if (pl_row > pl_last) begin
        pl_row = 0;
        pl_pos++;
        if (pl_pos >= pl_orders || pl_pos > 254) pl_pos = 0;
      end
    end
  endtask

  task automatic send_cmd(input logic [2:0] op);
    jump_req_t q;
    q = random_req();
    q.cmd = op;
    q.pos = 8'(pl_pos);
    q.row = 8'(pl_row);
    q.plr = 8'(pl_last);
    q.orders = 8'(pl_orders);
    if (op == lrj_pkg::OP_START) begin
      q.playing = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) != 0) q.rrows = 8'($urandom_range(0, 64));
    end
    send_req(q, 1'b0, NO_JUMP);
  endtask

  task automatic note_mismatch(input string what, input jump_res_t want, input jump_res_t got);
    n_bad++;
    if (n_bad <= 10)
      $display("mismatch (%s) at %0t: expected set=%0d pos=%0d row=%0d cancel=%0d roll=%0d, %s",
               what, $realtime, want.set, want.pos, want.row, want.cancel, want.roll,
               $sformatf("got set=%0d pos=%0d row=%0d cancel=%0d roll=%0d",
                         got.set, got.pos, got.row, got.cancel, got.roll));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res = '{jump_set, jump_pos, jump_row, jump_cancel, roll_on};
      if (pending_jumps.size() == 0) begin
        note_mismatch("no request outstanding", NO_JUMP, got_res);
      end else begin
        want_res = pending_jumps.pop_front();
        if (got_res !== want_res) note_mismatch("field", want_res, got_res);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int kind;
    clear_roll_state();
    pl_pos = 0;
    pl_row = 0;
    pl_last = 63;
    pl_orders = 8;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].res);
    while (n_items < N_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) send_req(random_req(), 1'b0, NO_JUMP);
      end else if (kind <= 5) begin
        // roll session with the odd stop, restart and paused frame
        new_song();
        send_cmd(lrj_pkg::OP_START);
        repeat ($urandom_range(8, 40)) begin
          case ($urandom_range(0, 39))
            0: send_cmd(lrj_pkg::OP_STOP);
            1: send_cmd(lrj_pkg::OP_START);
            2, 3, 4: send_frame(1'b0);
            default: send_frame(1'b1);
          endcase
        end
      end else if (kind <= 7) begin
        if ($urandom_range(0, 1) == 0) new_song();
        send_cmd(lrj_pkg::OP_CUE);
        repeat ($urandom_range(4, 20)) send_frame($urandom_range(0, 7) != 0);
      end else if (kind == 8) begin
        send_cmd(lrj_pkg::OP_LOCK);
        repeat ($urandom_range(4, 20)) send_frame($urandom_range(0, 7) != 0);
      end else begin
        send_cmd(3'($urandom_range(lrj_pkg::OP_START, lrj_pkg::OP_CLEAR)));
      end
    end
    in_valid <= 1'b0;
    while (pending_jumps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_bad == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
